// File: rtl/core/bitmap_block_allocator_top_defines.svh
// assertion macros for the block allocator
`ifndef BITMAP_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

`ifndef SYNTH

// checked outside reset, on clk_i
`define BBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define BBA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define BBA_ASSERT(lbl, prop, msg)
`define BBA_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: rtl/core/bba_pkg.sv
`default_nettype none

package bba_pkg;

  localparam int unsigned MAX_BLOCKS_DEF = 1024;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned BIT_W    = 5;
  localparam int unsigned IDX_W    = 11;
  localparam int unsigned WIDX_W   = IDX_W - BIT_W;
  localparam int unsigned CNT_W    = 11;
  localparam int unsigned IN_IDX_W = 10;

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  localparam logic [CNT_W-1:0] POOL_SIZE_RST = 11'd1024;

  typedef enum logic {
    REG_POOL_SIZE = 1'b0,
    REG_NONE      = 1'b1
  } reg_idx_e;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic [IN_IDX_W-1:0] block_index;
  } item_t;

  typedef struct packed {
    logic [IN_IDX_W-1:0] alloc_index;
    logic                alloc_found;
    logic                free_done;
    logic [CNT_W-1:0]    used_count;
  } result_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic issue;
    logic alloc_commit;
    logic alloc_fail;
    logic free_rd;
    logic free_wr;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic hit;
    logic scan_end;
  } status_t;

endpackage

`default_nettype wire

// File: rtl/core/bba_ram.sv
`default_nettype none

module bba_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/core/bba_ctrl.sv
`default_nettype none

module bba_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  bba_pkg::kind_e  kind_i,
  input  bba_pkg::status_t status_i,
  output bba_pkg::cmd_t   cmd_o,
  output logic            busy_o
);

`include "bitmap_block_allocator_top_defines.svh"

  typedef enum logic [4:0] {
    ST_CLEAR   = 5'b00001,
    ST_IDLE    = 5'b00010,
    ST_SCAN    = 5'b00100,
    ST_FREE_RD = 5'b01000,
    ST_FREE_WR = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = (state_q != ST_IDLE);
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = (kind_i == bba_pkg::KIND_ALLOC) ? ST_SCAN : ST_FREE_RD;
        end
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (status_i.hit) begin
          cmd_o.alloc_commit = 1'b1;
          state_d            = ST_IDLE;
        end else if (status_i.scan_end) begin
          cmd_o.alloc_fail = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_FREE_RD: begin
        cmd_o.free_rd = 1'b1;
        state_d       = ST_FREE_WR;
      end
      ST_FREE_WR: begin
        cmd_o.free_wr = 1'b1;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  `BBA_ASSERT_ALWAYS(a_busy_in_reset, !rst_ni |=> busy_o, "not busy after reset")

endmodule

`default_nettype wire

// File: rtl/core/bba_dp.sv
`default_nettype none

module bba_dp #(
  parameter int unsigned MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  bba_pkg::cmd_t                      cmd_i,
  input  logic [bba_pkg::CNT_W-1:0]          pool_size_i,
  input  bba_pkg::item_t                     item_i,
  output bba_pkg::status_t                   status_o,
  output logic                               done_o,
  output bba_pkg::result_t                   result_o
);

`include "bitmap_block_allocator_top_defines.svh"

  localparam int unsigned WORD_W = bba_pkg::WORD_W;
  localparam int unsigned BIT_W  = bba_pkg::BIT_W;
  localparam int unsigned IDX_W  = bba_pkg::IDX_W;
  localparam int unsigned WIDX_W = bba_pkg::WIDX_W;
  localparam int unsigned CNT_W  = bba_pkg::CNT_W;
  localparam int unsigned DEPTH  = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned IDX_CAP = 1 << bba_pkg::IN_IDX_W;
  localparam int unsigned EFF_CAP = (MAX_BLOCKS > IDX_CAP) ? IDX_CAP : MAX_BLOCKS;
  localparam logic [IDX_W-1:0] MAX_EFF = IDX_W'(EFF_CAP);

  function automatic logic [AW-1:0] to_addr(input logic [WIDX_W-1:0] w);
    logic [31:0] t;
    t = 32'(w);
    return t[AW-1:0];
  endfunction

  // item and bookkeeping
  bba_pkg::item_t                  item_q;
  logic [bba_pkg::IN_IDX_W-1:0]    hint_q;
  logic [CNT_W-1:0]                cnt_q, cnt_d;
  logic [AW-1:0]                   clr_cnt_q;

  // scan issue and check stages
  logic [WIDX_W-1:0] iss_word_q;
  logic              iss_wrap_q;
  logic              iss_live_q;
  logic [WIDX_W-1:0] chk_word_q;
  logic              chk_wrap_q;
  logic              chk_final_q;
  logic              chk_valid_q;

  bba_pkg::result_t res_q;
  logic             done_q;

  logic [IDX_W-1:0]  eff;
  logic [IDX_W-1:0]  start_idx;
  logic [WIDX_W-1:0] start_word;
  logic [WIDX_W-1:0] last_word;
  logic              iss_final;

  logic [WORD_W-1:0] rd_data;
  logic [WORD_W-1:0] avail;
  logic [BIT_W-1:0]  hit_bit;
  logic [WORD_W-1:0] hit_oh;
  logic              hit;
  logic [IDX_W-1:0]  hit_idx;

  logic [WIDX_W-1:0] free_word;
  logic [WORD_W-1:0] free_oh;
  logic              free_ok;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;

  assign eff        = (pool_size_i > MAX_EFF) ? MAX_EFF : pool_size_i;
  assign start_idx  = ({1'b0, hint_q} < eff) ? {1'b0, hint_q} : '0;
  assign start_word = start_idx[IDX_W-1:BIT_W];
  assign last_word  = (eff == '0) ? '0 : WIDX_W'((eff - IDX_W'(1)) >> BIT_W);
  assign iss_final  = iss_wrap_q && (iss_word_q == start_word);

  // bits of the checked word that belong to this pass of the search
  always_comb begin
    logic [IDX_W-1:0] idx_v;
    for (int b = 0; b < WORD_W; b++) begin
      idx_v    = {chk_word_q, BIT_W'(b)};
      avail[b] = !rd_data[b] && (idx_v < eff) &&
                 (chk_wrap_q ? (idx_v < start_idx) : (idx_v >= start_idx));
    end
  end

  always_comb begin
    hit_bit = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (avail[b]) begin
        hit_bit = BIT_W'(b);
      end
    end
  end

  assign hit     = chk_valid_q && (avail != '0);
  assign hit_oh  = WORD_W'(1) << hit_bit;
  assign hit_idx = {chk_word_q, hit_bit};

  assign free_word = WIDX_W'(item_q.block_index >> BIT_W);
  assign free_oh   = WORD_W'(1) << item_q.block_index[BIT_W-1:0];
  assign free_ok   = ({1'b0, item_q.block_index} < eff) && ((rd_data & free_oh) != '0);

  assign status_o.clr_last = (clr_cnt_q == AW'(DEPTH - 1));
  assign status_o.hit      = hit;
  assign status_o.scan_end = chk_valid_q && chk_final_q && !hit;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_cnt_q;
    ram_wdata = '0;
    if (cmd_i.clear) begin
      ram_we = 1'b1;
    end else if (cmd_i.alloc_commit) begin
      ram_we    = 1'b1;
      ram_waddr = to_addr(chk_word_q);
      ram_wdata = rd_data | hit_oh;
    end else if (cmd_i.free_wr) begin
      ram_we    = free_ok;
      ram_waddr = to_addr(free_word);
      ram_wdata = rd_data & ~free_oh;
    end
  end

  assign ram_raddr = cmd_i.free_rd ? to_addr(free_word) : to_addr(iss_word_q);

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.alloc_commit) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (cmd_i.free_wr && free_ok) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  bba_ram #(
    .WIDTH  (WORD_W),
    .DEPTH  (DEPTH),
    .ADDR_W (AW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hint_q      <= '0;
      cnt_q       <= '0;
      clr_cnt_q   <= '0;
      iss_live_q  <= 1'b0;
      chk_valid_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      done_q      <= cmd_i.alloc_commit || cmd_i.alloc_fail || cmd_i.free_wr;
      chk_valid_q <= cmd_i.issue && iss_live_q && !hit;
      if (cmd_i.clear) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      if (cmd_i.load) begin
        iss_live_q <= 1'b1;
      end else if (cmd_i.issue && iss_live_q) begin
        iss_live_q <= !iss_final;
      end
      if (cmd_i.alloc_commit) begin
        hint_q <= hit_idx[bba_pkg::IN_IDX_W-1:0];
      end else if (cmd_i.alloc_fail) begin
        hint_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q     <= item_i;
      iss_word_q <= start_word;
      iss_wrap_q <= 1'b0;
    end else if (cmd_i.issue) begin
      if (iss_word_q == last_word) begin
        iss_word_q <= '0;
        iss_wrap_q <= 1'b1;
      end else begin
        iss_word_q <= iss_word_q + WIDX_W'(1);
      end
    end
    chk_word_q  <= iss_word_q;
    chk_wrap_q  <= iss_wrap_q;
    chk_final_q <= iss_final;
    if (cmd_i.alloc_commit) begin
      res_q.alloc_index <= hit_idx[bba_pkg::IN_IDX_W-1:0];
      res_q.alloc_found <= 1'b1;
      res_q.free_done   <= 1'b0;
      res_q.used_count  <= cnt_d;
    end else if (cmd_i.alloc_fail || cmd_i.free_wr) begin
      res_q.alloc_index <= '0;
      res_q.alloc_found <= 1'b0;
      res_q.free_done   <= cmd_i.free_wr && free_ok;
      res_q.used_count  <= cnt_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  `BBA_ASSERT(a_commit_clear_bit, cmd_i.alloc_commit |-> ((rd_data & hit_oh) == '0), "allocated bit already set")
  `BBA_ASSERT(a_cnt_source, (cnt_q != $past(cnt_q)) |-> ($past(cmd_i.alloc_commit) || $past(cmd_i.free_wr)), "count moved without a transaction")

endmodule

`default_nettype wire

// File: rtl/core/bitmap_block_allocator_top.sv
`default_nettype none
// allocate: the search walks the 32-bit map words covering the pool, starting at the hint and wrapping,
// one word checked per cycle through the map memory read port
// free: one read and one write of the map word before done_o
// busy falls with done_o, so no new transaction is taken before the last is done; no stall
// after reset the map is cleared one word a cycle, busy high meanwhile

module bitmap_block_allocator_top #(
  parameter int unsigned MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bba_pkg::APB_AW-1:0]   paddr,
  input  logic [bba_pkg::APB_DW-1:0]   pwdata,
  output logic [bba_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  input  logic                         start,
  output logic                         busy,
  input  bba_pkg::item_t               item_i,
  output logic                         done_o,
  output bba_pkg::result_t             result_o
);

`include "bitmap_block_allocator_top_defines.svh"

  logic [bba_pkg::CNT_W-1:0] pool_size_q;
  bba_pkg::reg_idx_e         reg_idx;
  logic                      cfg_wr;

  bba_pkg::cmd_t    cmd;
  bba_pkg::status_t status;

  assign pready  = 1'b1;
  assign reg_idx = bba_pkg::reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      bba_pkg::REG_POOL_SIZE: prdata = bba_pkg::APB_DW'(pool_size_q);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_size_q <= bba_pkg::POOL_SIZE_RST;
    end else if (cfg_wr && (reg_idx == bba_pkg::REG_POOL_SIZE)) begin
      pool_size_q <= pwdata[bba_pkg::CNT_W-1:0];
    end
  end

  bba_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .kind_i   (item_i.kind),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  bba_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .pool_size_i (pool_size_q),
    .item_i      (item_i),
    .status_o    (status),
    .done_o      (done_o),
    .result_o    (result_o)
  );

  `BBA_ASSERT(a_done_single, done_o |=> !done_o, "result strobe longer than one cycle")
  `BBA_ASSERT(a_done_after_busy, done_o |-> $past(busy), "result without a transaction in flight")

endmodule

`default_nettype wire
